// ===== hdl/mkpts_pkg.sv =====
`default_nettype none
package mkpts_pkg;

	// slot table size and derived widths
	localparam int SLOTS  = 8;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CMP_W  = (SLOT_W > 3) ? SLOT_W : 3;
	localparam int CNT_W  = SLOT_W;

	// fixed field widths
	localparam int CMD_W   = 2;
	localparam int INS_W   = 3;
	localparam int TIME_W  = 16;
	localparam int BURST_W = 8;
	localparam int PRIO_W  = 8;
	localparam int NEED_W  = TIME_W + 1;
	localparam int TOTAL_W = 20;
	localparam int POL_W   = 2;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};

	// commands
	localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

	// selection policies
	localparam logic [POL_W-1:0] POL_ARRIVAL = 2'd0;
	localparam logic [POL_W-1:0] POL_BURST   = 2'd1;
	localparam logic [POL_W-1:0] POL_PRIO    = 2'd2;

	// configuration register indexes
	localparam logic REG_POLICY  = 1'b0;
	localparam logic REG_PREEMPT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_REPORT
	} state_t;

	// candidate handed from cell to cell during the minimum scan
	typedef struct packed {
		logic              valid;
		logic              forced;
		logic [TIME_W-1:0] key;
		logic [SLOT_W-1:0] idx;
		logic [NEED_W-1:0] need;
		logic              last;
	} cand_t;

	// slot write and update strobes from the sequencer
	typedef struct packed {
		logic               we;
		logic               restart;
		logic               dec;
		logic [TIME_W-1:0]  arrival;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
	} slot_ctl_t;

	// scan context shared by every cell
	typedef struct packed {
		logic [POL_W-1:0]  policy;
		logic              force_en;
		logic [SLOT_W-1:0] run_slot;
		logic [TIME_W-1:0] now;
	} scan_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/mkpts_cell.sv =====
`default_nettype none
module mkpts_cell (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [mkpts_pkg::SLOT_W-1:0] idx,
	input  wire mkpts_pkg::slot_ctl_t   ctl,
	input  wire mkpts_pkg::scan_ctl_t   scan,
	input  wire mkpts_pkg::cand_t       cand_in,
	output mkpts_pkg::cand_t            cand_out,
	output logic                        busy
);

	logic [mkpts_pkg::TIME_W-1:0]  arrive_q;
	logic [mkpts_pkg::BURST_W-1:0] orig_q;
	logic [mkpts_pkg::BURST_W-1:0] left_q;
	logic [mkpts_pkg::PRIO_W-1:0]  prio_q;
	mkpts_pkg::cand_t              cand_q;

	logic [mkpts_pkg::TIME_W-1:0] key;
	logic                         force_here;
	logic                         eligible;
	mkpts_pkg::cand_t             mine;
	mkpts_pkg::cand_t             cand_d;

	assign busy = (left_q != '0);

	// slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arrive_q <= '0;
			orig_q   <= '0;
			left_q   <= '0;
			prio_q   <= '0;
		end else if (ctl.we) begin
			arrive_q <= ctl.arrival;
			orig_q   <= ctl.burst;
			left_q   <= ctl.burst;
			prio_q   <= ctl.prio;
		end else if (ctl.restart) begin
			left_q <= orig_q;
		end else if (ctl.dec) begin
			left_q <= left_q - 1'b1;
		end
	end

	// selection key
	always_comb begin
		case (scan.policy)
			mkpts_pkg::POL_BURST: key = {{(mkpts_pkg::TIME_W-mkpts_pkg::BURST_W){1'b0}}, left_q};
			mkpts_pkg::POL_PRIO:  key = {{(mkpts_pkg::TIME_W-mkpts_pkg::PRIO_W){1'b0}}, prio_q};
			default:              key = arrive_q;
		endcase
	end

	// this slot as a candidate
	assign force_here = scan.force_en && (scan.run_slot == idx) && busy;
	assign eligible   = force_here || ((scan.now >= arrive_q) && busy);

	always_comb begin
		mine.valid  = eligible;
		mine.forced = force_here;
		mine.key    = key;
		mine.idx    = idx;
		mine.need   = {1'b0, arrive_q} + {{(mkpts_pkg::NEED_W-mkpts_pkg::BURST_W){1'b0}}, orig_q};
		mine.last   = (left_q == {{(mkpts_pkg::BURST_W-1){1'b0}}, 1'b1});
	end

	// running minimum, strict compare keeps the lower slot on ties
	always_comb begin
		cand_d = cand_in;
		if (!cand_in.forced) begin
			if (force_here) begin
				cand_d = mine;
			end else if (eligible && (!cand_in.valid || (key < cand_in.key))) begin
				cand_d = mine;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else begin
			cand_q <= cand_d;
		end
	end

	assign cand_out = cand_q;

endmodule
`default_nettype wire

// ===== hdl/min_key_process_tick_scheduler_top.sv =====
`default_nettype none
// channel | signals                              | direction
// input   | in_valid, in_stall, cmd..prio        | item in, in_stall driven here
// output  | out_valid, out_stall, ran_slot..now  | result out, out_stall from sink
// config  | cfg_valid, cfg_ready, cfg_index/data | register write, always ready
//
// load, restart and unused commands go from the input transfer through the apply and
// report states to the output register; a tick first passes the scan state, where the
// minimum scan walks the cell row. one item is in flight at a time; the next is taken
// the cycle after the result is registered, while that result may still wait under
// out_stall.
// reset clears the slot table, time, wait total and running job at once.
module min_key_process_tick_scheduler_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [2:0]  slot,
	input  wire logic [15:0] arrival,
	input  wire logic [7:0]  burst,
	input  wire logic [7:0]  prio,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       ran_slot,
	output logic             idle,
	output logic             all_done,
	output logic             finished,
	output logic [15:0]      slot_wait,
	output logic [19:0]      total_wait,
	output logic [15:0]      now,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [1:0]  cfg_data
);

	mkpts_pkg::state_t state_q, state_d;
	logic [mkpts_pkg::CNT_W-1:0] cnt_q;

	// configuration
	logic [mkpts_pkg::POL_W-1:0] policy_q;
	logic                        preempt_q;

	// captured item
	logic [mkpts_pkg::CMD_W-1:0]   cmd_q;
	logic [mkpts_pkg::INS_W-1:0]   slot_q;
	logic [mkpts_pkg::TIME_W-1:0]  arrival_q;
	logic [mkpts_pkg::BURST_W-1:0] burst_q;
	logic [mkpts_pkg::PRIO_W-1:0]  prio_q;

	// scheduler state
	logic [mkpts_pkg::TIME_W-1:0]  clock_q;
	logic [mkpts_pkg::TOTAL_W-1:0] sum_q;
	logic [mkpts_pkg::SLOT_W-1:0]  run_slot_q;
	logic                          run_valid_q;

	// per-item results
	logic [mkpts_pkg::SLOT_W-1:0] res_ran_q;
	logic                         res_idle_q;
	logic                         res_fin_q;
	logic [mkpts_pkg::TIME_W-1:0] res_wait_q;

	// output register
	logic                          out_valid_q;
	logic [2:0]                    o_ran_q;
	logic                          o_idle_q;
	logic                          o_done_q;
	logic                          o_fin_q;
	logic [mkpts_pkg::TIME_W-1:0]  o_wait_q;
	logic [mkpts_pkg::TOTAL_W-1:0] o_total_q;
	logic [mkpts_pkg::TIME_W-1:0]  o_now_q;

	mkpts_pkg::cand_t     chain [mkpts_pkg::SLOTS+1];
	mkpts_pkg::slot_ctl_t ctl   [mkpts_pkg::SLOTS];
	mkpts_pkg::scan_ctl_t scan;
	logic [mkpts_pkg::SLOTS-1:0] busy;

	mkpts_pkg::cand_t pick;
	logic in_xfer, out_xfer, out_free;
	logic apply, report, any_work, tick_run;
	logic load_ok;
	logic [mkpts_pkg::CMP_W-1:0]  slot_ext;
	logic [mkpts_pkg::TIME_W-1:0] clock_inc;
	logic [mkpts_pkg::NEED_W-1:0] clock_ext;
	logic [mkpts_pkg::TOTAL_W:0]  sum_add;
	logic [mkpts_pkg::TOTAL_W-1:0] sum_next;

	assign in_stall  = (state_q != mkpts_pkg::ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_xfer  = out_valid_q && !out_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign apply  = (state_q == mkpts_pkg::ST_APPLY);
	assign report = (state_q == mkpts_pkg::ST_REPORT) && out_free;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= mkpts_pkg::POL_ARRIVAL;
			preempt_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mkpts_pkg::REG_POLICY:  policy_q  <= cfg_data;
				mkpts_pkg::REG_PREEMPT: preempt_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mkpts_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == mkpts_pkg::ST_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mkpts_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = (cmd == mkpts_pkg::CMD_TICK) ? mkpts_pkg::ST_SCAN
					                                       : mkpts_pkg::ST_APPLY;
				end
			end
			mkpts_pkg::ST_SCAN: begin
				if (cnt_q == mkpts_pkg::CNT_W'(mkpts_pkg::SLOTS - 1)) begin
					state_d = mkpts_pkg::ST_APPLY;
				end
			end
			mkpts_pkg::ST_APPLY: begin
				state_d = mkpts_pkg::ST_REPORT;
			end
			mkpts_pkg::ST_REPORT: begin
				if (out_free) begin
					state_d = mkpts_pkg::ST_IDLE;
				end
			end
			default: state_d = mkpts_pkg::ST_IDLE;
		endcase
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q     <= cmd;
			slot_q    <= slot;
			arrival_q <= arrival;
			burst_q   <= burst;
			prio_q    <= prio;
		end
	end

	// scan context and cell row
	assign scan.policy   = policy_q;
	assign scan.force_en = !preempt_q && run_valid_q;
	assign scan.run_slot = run_slot_q;
	assign scan.now      = clock_q;
	assign chain[0]      = '0;
	assign pick          = chain[mkpts_pkg::SLOTS];

	assign any_work = |busy;
	assign tick_run = apply && (cmd_q == mkpts_pkg::CMD_TICK) && any_work && pick.valid;
	assign slot_ext = mkpts_pkg::CMP_W'(slot_q);
	assign load_ok  = apply && (cmd_q == mkpts_pkg::CMD_LOAD) &&
	                  ({1'b0, slot_ext} < (mkpts_pkg::CMP_W+1)'(mkpts_pkg::SLOTS));

	for (genvar i = 0; i < mkpts_pkg::SLOTS; i++) begin : g_cell
		always_comb begin
			ctl[i].we      = load_ok && (slot_ext == mkpts_pkg::CMP_W'(i));
			ctl[i].restart = apply && (cmd_q == mkpts_pkg::CMD_RESTART);
			ctl[i].dec     = tick_run && (pick.idx == mkpts_pkg::SLOT_W'(i));
			ctl[i].arrival = arrival_q;
			ctl[i].burst   = burst_q;
			ctl[i].prio    = prio_q;
		end

		mkpts_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (mkpts_pkg::SLOT_W'(i)),
			.ctl      (ctl[i]),
			.scan     (scan),
			.cand_in  (chain[i]),
			.cand_out (chain[i+1]),
			.busy     (busy[i])
		);
	end

	// time after the tick and wait of a finishing slot
	assign clock_inc = (clock_q != mkpts_pkg::TIME_MAX) ? clock_q + 1'b1 : clock_q;
	assign clock_ext = {1'b0, clock_inc};

	// apply the item to time, running job and per-item results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q     <= '0;
			run_slot_q  <= '0;
			run_valid_q <= 1'b0;
		end else if (apply) begin
			case (cmd_q)
				mkpts_pkg::CMD_LOAD: begin
					if (load_ok && run_valid_q &&
					    (slot_ext == mkpts_pkg::CMP_W'(run_slot_q))) begin
						run_valid_q <= 1'b0;
					end
				end
				mkpts_pkg::CMD_RESTART: begin
					clock_q     <= '0;
					run_slot_q  <= '0;
					run_valid_q <= 1'b0;
				end
				mkpts_pkg::CMD_TICK: begin
					if (any_work) begin
						clock_q <= clock_inc;
						if (!pick.valid) begin
							run_valid_q <= 1'b0;
						end else begin
							run_slot_q  <= pick.idx;
							run_valid_q <= !pick.last;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			res_ran_q  <= tick_run ? pick.idx : '0;
			res_idle_q <= (cmd_q == mkpts_pkg::CMD_TICK) && !(any_work && pick.valid);
			res_fin_q  <= tick_run && pick.last;
			if (tick_run && pick.last && (clock_ext > pick.need)) begin
				res_wait_q <= mkpts_pkg::TIME_W'(clock_ext - pick.need);
			end else begin
				res_wait_q <= '0;
			end
		end
	end

	// saturating wait total
	assign sum_add  = {1'b0, sum_q} + {{(mkpts_pkg::TOTAL_W+1-mkpts_pkg::TIME_W){1'b0}}, res_wait_q};
	assign sum_next = sum_add[mkpts_pkg::TOTAL_W] ? mkpts_pkg::TOTAL_MAX
	                                              : sum_add[mkpts_pkg::TOTAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (apply && (cmd_q == mkpts_pkg::CMD_RESTART)) begin
			sum_q <= '0;
		end else if (report) begin
			sum_q <= sum_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (report) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (report) begin
			o_ran_q   <= 3'(res_ran_q);
			o_idle_q  <= res_idle_q;
			o_done_q  <= !any_work;
			o_fin_q   <= res_fin_q;
			o_wait_q  <= res_wait_q;
			o_total_q <= sum_next;
			o_now_q   <= clock_q;
		end
	end

	assign ran_slot   = o_ran_q;
	assign idle       = o_idle_q;
	assign all_done   = o_done_q;
	assign finished   = o_fin_q;
	assign slot_wait  = o_wait_q;
	assign total_wait = o_total_q;
	assign now        = o_now_q;

endmodule
`default_nettype wire
